// ----- rtl/core/mh64i_pkg.sv -----
// ----------------------------------------------------------------------------
// mh64i_pkg
// Shared constants, state and command types for the interleaved 64-bit
// murmur hash unit.
// ----------------------------------------------------------------------------
package mh64i_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned HashWidth  = 64;

  localparam logic [WordWidth-1:0]  HashMult  = 32'h5bd1e995;
  localparam logic [WordWidth-1:0]  SeedOne   = 32'hc86b14f7;
  localparam logic [WordWidth-1:0]  SeedTwo   = 32'h650f5c4d;
  localparam int unsigned           MixShift  = 24;
  localparam int unsigned           FinShiftA = 18;
  localparam int unsigned           FinShiftB = 22;
  localparam int unsigned           FinShiftC = 17;
  localparam logic [CountWidth-1:0] FullCount = 3'd4;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_FOLD,
    S_FIN0,
    S_FIN1,
    S_FIN2,
    S_FIN3
  } state_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MIX1,
    OP_MIX2,
    OP_FOLD,
    OP_FIN0,
    OP_FIN1,
    OP_FIN2,
    OP_FIN3
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_full;   // incoming item carries a full word
    logic last;      // held item closes the message
    logic out_free;  // output register can take a new hash
  } dp_stat_t;

endpackage

// ----- rtl/core/mh64i_ctrl.sv -----
// ----------------------------------------------------------------------------
// mh64i_ctrl
// Sequencer: steps the shared multiplier through word mixing, lane folding
// and the final cross-mix, and drives the input stall.
// ----------------------------------------------------------------------------
module mh64i_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mh64i_pkg::dp_stat_t stat,
  output mh64i_pkg::dp_cmd_t  cmd
);

  mh64i_pkg::state_t state;
  mh64i_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mh64i_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mh64i_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_full ? mh64i_pkg::S_MIX1 : mh64i_pkg::S_FIN0;
        end
      end
      mh64i_pkg::S_MIX1: state_next = mh64i_pkg::S_MIX2;
      mh64i_pkg::S_MIX2: state_next = mh64i_pkg::S_FOLD;
      mh64i_pkg::S_FOLD: begin
        state_next = stat.last ? mh64i_pkg::S_FIN0 : mh64i_pkg::S_IDLE;
      end
      mh64i_pkg::S_FIN0: state_next = mh64i_pkg::S_FIN1;
      mh64i_pkg::S_FIN1: state_next = mh64i_pkg::S_FIN2;
      mh64i_pkg::S_FIN2: state_next = mh64i_pkg::S_FIN3;
      mh64i_pkg::S_FIN3: begin
        if (stat.out_free) begin
          state_next = mh64i_pkg::S_IDLE;
        end
      end
      default: state_next = mh64i_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op   = mh64i_pkg::OP_NONE;
    in_stall = 1'b1;
    unique case (state)
      mh64i_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = mh64i_pkg::OP_LOAD;
        end
      end
      mh64i_pkg::S_MIX1: cmd.op = mh64i_pkg::OP_MIX1;
      mh64i_pkg::S_MIX2: cmd.op = mh64i_pkg::OP_MIX2;
      mh64i_pkg::S_FOLD: cmd.op = mh64i_pkg::OP_FOLD;
      mh64i_pkg::S_FIN0: cmd.op = mh64i_pkg::OP_FIN0;
      mh64i_pkg::S_FIN1: cmd.op = mh64i_pkg::OP_FIN1;
      mh64i_pkg::S_FIN2: cmd.op = mh64i_pkg::OP_FIN2;
      mh64i_pkg::S_FIN3: begin
        if (stat.out_free) begin
          cmd.op = mh64i_pkg::OP_FIN3;
        end
      end
      default: cmd.op = mh64i_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- rtl/core/mh64i_datapath.sv -----
// ----------------------------------------------------------------------------
// mh64i_datapath
// Hash lanes, item holding registers, one shared 32x32 multiplier and the
// output register.
// ----------------------------------------------------------------------------
module mh64i_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [mh64i_pkg::WordWidth-1:0]        data_word,
  input  logic [mh64i_pkg::CountWidth-1:0]       byte_count,
  input  logic [mh64i_pkg::WordWidth-1:0]        message_length,
  input  logic                                   first_word,
  input  logic                                   last_word,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mh64i_pkg::HashWidth-1:0]        hash_value,
  input  mh64i_pkg::dp_cmd_t                     cmd,
  output mh64i_pkg::dp_stat_t                    stat
);

  logic [mh64i_pkg::WordWidth-1:0] lane_one;
  logic [mh64i_pkg::WordWidth-1:0] lane_two;
  logic                            odd_word;
  logic [mh64i_pkg::WordWidth-1:0] word_reg;
  logic [1:0]                      tail_cnt;
  logic                            full_reg;
  logic                            last_reg;
  logic [mh64i_pkg::WordWidth-1:0] k_reg;
  logic [mh64i_pkg::WordWidth-1:0] a_reg;
  logic [mh64i_pkg::WordWidth-1:0] b_reg;

  logic [mh64i_pkg::WordWidth-1:0] tail_mask;
  logic [mh64i_pkg::WordWidth-1:0] mul_in;
  logic [mh64i_pkg::WordWidth-1:0] prod;

  // status toward the controller
  assign stat.in_full  = !last_word || (byte_count >= mh64i_pkg::FullCount);
  assign stat.last     = last_reg;
  assign stat.out_free = !out_valid || !out_stall;

  // valid bytes of a partial tail word
  always_comb begin
    case (tail_cnt)
      2'd0:    tail_mask = 32'h0000_0000;
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      default: tail_mask = 32'h00ff_ffff;
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      mh64i_pkg::OP_MIX1: mul_in = word_reg;
      mh64i_pkg::OP_MIX2: mul_in = k_reg;
      mh64i_pkg::OP_FOLD: mul_in = odd_word ? lane_two : lane_one;
      mh64i_pkg::OP_FIN0: mul_in = full_reg ? lane_two : (lane_two ^ (word_reg & tail_mask));
      mh64i_pkg::OP_FIN1: mul_in = a_reg;
      mh64i_pkg::OP_FIN2: mul_in = b_reg ^ (a_reg >> mh64i_pkg::FinShiftB);
      mh64i_pkg::OP_FIN3: mul_in = a_reg ^ (b_reg >> mh64i_pkg::FinShiftC);
      default:            mul_in = a_reg;
    endcase
  end

  // shared multiplier, low half of the product
  assign prod = mul_in * mh64i_pkg::HashMult;

  // lanes and word position
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_one <= '0;
      lane_two <= '0;
      odd_word <= 1'b0;
    end else begin
      case (cmd.op)
        mh64i_pkg::OP_LOAD: begin
          if (first_word) begin
            lane_one <= mh64i_pkg::SeedOne ^ message_length;
            lane_two <= mh64i_pkg::SeedTwo;
            odd_word <= 1'b0;
          end
        end
        mh64i_pkg::OP_FOLD: begin
          if (odd_word) begin
            lane_two <= prod ^ k_reg;
          end else begin
            lane_one <= prod ^ k_reg;
          end
          odd_word <= !odd_word;
        end
        default: begin
        end
      endcase
    end
  end

  // item holding and working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      mh64i_pkg::OP_LOAD: begin
        word_reg <= data_word;
        tail_cnt <= byte_count[1:0];
        full_reg <= stat.in_full;
        last_reg <= last_word;
      end
      mh64i_pkg::OP_MIX1: k_reg <= prod ^ (prod >> mh64i_pkg::MixShift);
      mh64i_pkg::OP_MIX2: k_reg <= prod;
      mh64i_pkg::OP_FIN0: begin
        b_reg <= prod;
        a_reg <= lane_one ^ (prod >> mh64i_pkg::FinShiftA);
      end
      mh64i_pkg::OP_FIN1: a_reg <= prod;
      mh64i_pkg::OP_FIN2: b_reg <= prod;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == mh64i_pkg::OP_FIN3) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mh64i_pkg::OP_FIN3) begin
      hash_value <= {prod, b_reg};
    end
  end

endmodule

// ----- rtl/core/murmur_hash_64_interleaved_unit.sv -----
// Sequence: a full word is taken in IDLE, then goes three times through the one
// shared 32x32 multiplier (MIX1, MIX2, FOLD) before the next item can be taken.
// A last item adds the cross-mix (FIN0 to FIN3); a partial tail goes straight to it.
// out_valid rises when FIN3 loads the output register, which waits while a hash is stalled.
// in_stall is high outside IDLE, so no new item is taken while one is in work.
// Reset (rst, synchronous): lanes and word position cleared, no hash pending.
// ----------------------------------------------------------------------------
// murmur_hash_64_interleaved_unit
// Streaming two-lane murmur hash giving one 64-bit value per message.
// ----------------------------------------------------------------------------
module murmur_hash_64_interleaved_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [mh64i_pkg::WordWidth-1:0]        data_word,
  input  logic [mh64i_pkg::CountWidth-1:0]       byte_count,
  input  logic [mh64i_pkg::WordWidth-1:0]        message_length,
  input  logic                                   first_word,
  input  logic                                   last_word,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mh64i_pkg::HashWidth-1:0]        hash_value
);

  mh64i_pkg::dp_cmd_t  cmd;
  mh64i_pkg::dp_stat_t stat;

  // sequencer
  mh64i_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // lanes, multiplier and output register
  mh64i_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .data_word      (data_word),
    .byte_count     (byte_count),
    .message_length (message_length),
    .first_word     (first_word),
    .last_word      (last_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hash_value     (hash_value),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ----- tb/mh64i_hash_checker.sv -----
// ----------------------------------------------------------------------------
// mh64i_hash_checker
// Watches both channels of the interleaved murmur hash unit. Every input
// transfer runs through a local two-lane hash model. Each hash that model
// predicts is queued and then compared with the next hash transfer.
// ----------------------------------------------------------------------------
module mh64i_hash_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [mh64i_pkg::WordWidth-1:0]       data_word,
  input  logic [mh64i_pkg::CountWidth-1:0]      byte_count,
  input  logic [mh64i_pkg::WordWidth-1:0]       message_length,
  input  logic                                  first_word,
  input  logic                                  last_word,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [mh64i_pkg::HashWidth-1:0]       hash_value,
  output int                                    mismatch_count,
  output int                                    hashes_pending
);

  // model state: two hash lanes and word position
  logic [mh64i_pkg::WordWidth-1:0] lane_hi;
  logic [mh64i_pkg::WordWidth-1:0] lane_lo;
  logic                            at_odd_word;
  logic [mh64i_pkg::HashWidth-1:0] expected_hashes[$];

  initial begin
    mismatch_count = 0;
    hashes_pending = 0;
  end

  // low 32 bits of the product with the hash multiplier
  function automatic logic [mh64i_pkg::WordWidth-1:0] times_mult(
      input logic [mh64i_pkg::WordWidth-1:0] x);
    logic [mh64i_pkg::WordWidth-1:0] p;
    p = x * mh64i_pkg::HashMult;
    return p;
  endfunction

  // fold one transfer into the lanes, queue a hash when the message closes
  task automatic predict_hash(input logic [mh64i_pkg::WordWidth-1:0] word,
                              input logic [mh64i_pkg::CountWidth-1:0] cnt,
                              input logic [mh64i_pkg::WordWidth-1:0] len,
                              input logic is_first,
                              input logic is_last);
    logic [mh64i_pkg::WordWidth-1:0]  k;
    logic [mh64i_pkg::WordWidth-1:0]  a;
    logic [mh64i_pkg::WordWidth-1:0]  b;
    logic [mh64i_pkg::WordWidth-1:0]  tail_mask;
    logic [mh64i_pkg::CountWidth-1:0] used;
    if (is_first) begin
      lane_hi     = mh64i_pkg::SeedOne ^ len;
      lane_lo     = mh64i_pkg::SeedTwo;
      at_odd_word = 1'b0;
    end
    // counts only matter on the last word, and saturate at a full word
    used = (!is_last || cnt > mh64i_pkg::FullCount) ? mh64i_pkg::FullCount : cnt;
    if (used == mh64i_pkg::FullCount) begin
      k = times_mult(word);
      k = k ^ (k >> mh64i_pkg::MixShift);
      k = times_mult(k);
      if (at_odd_word) begin
        lane_lo = times_mult(lane_lo) ^ k;
      end else begin
        lane_hi = times_mult(lane_hi) ^ k;
      end
      at_odd_word = ~at_odd_word;
    end
    if (is_last) begin
      // final mix on copies, lanes keep their values
      a = lane_hi;
      b = lane_lo;
      if (used != mh64i_pkg::FullCount) begin
        tail_mask = (32'd1 << (int'(used) * 8)) - 32'd1;
        b = b ^ (word & tail_mask);
      end
      b = times_mult(b);
      a = a ^ (b >> mh64i_pkg::FinShiftA);
      a = times_mult(a);
      b = b ^ (a >> mh64i_pkg::FinShiftB);
      b = times_mult(b);
      a = a ^ (b >> mh64i_pkg::FinShiftC);
      a = times_mult(a);
      expected_hashes.push_back({a, b});
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      lane_hi     = '0;
      lane_lo     = '0;
      at_odd_word = 1'b0;
      expected_hashes.delete();
    end else begin
      // hash transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected hash transfer, expected none, actual %h",
                   $time, hash_value);
          mismatch_count++;
        end else begin
          if (hash_value !== expected_hashes[0]) begin
            $display("%0t: hash_value mismatch, expected %h, actual %h",
                     $time, expected_hashes[0], hash_value);
            mismatch_count++;
          end
          void'(expected_hashes.pop_front());
        end
      end
      // word transfer into the model
      if (in_valid && !in_stall) begin
        predict_hash(data_word, byte_count, message_length, first_word, last_word);
      end
    end
    hashes_pending = expected_hashes.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives word streams into the interleaved murmur hash unit: a directed set
// of corner messages, then random messages mixed with stray words, under
// random sender bursts and receiver stalls. The checker does the prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TargetItems = 1250;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 800000;

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [mh64i_pkg::WordWidth-1:0]      data_word;
  logic [mh64i_pkg::CountWidth-1:0]     byte_count;
  logic [mh64i_pkg::WordWidth-1:0]      message_length;
  logic                                 first_word;
  logic                                 last_word;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [mh64i_pkg::HashWidth-1:0]      hash_value;

  int mismatch_count;
  int hashes_pending;
  int items_sent;
  int burst_left;
  int cycle_count;
  bit hold_request;
  bit hold_done;

  murmur_hash_64_interleaved_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_word      (data_word),
    .byte_count     (byte_count),
    .message_length (message_length),
    .first_word     (first_word),
    .last_word      (last_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hash_value     (hash_value)
  );

  mh64i_hash_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_word      (data_word),
    .byte_count     (byte_count),
    .message_length (message_length),
    .first_word     (first_word),
    .last_word      (last_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hash_value     (hash_value),
    .mismatch_count (mismatch_count),
    .hashes_pending (hashes_pending)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run limit reached", $time);
      $display("status: fail");
      $finish;
    end
  end

  // offer one word and hold it until the transfer
  task automatic offer(input logic [mh64i_pkg::WordWidth-1:0] w,
                       input logic [mh64i_pkg::CountWidth-1:0] c,
                       input logic [mh64i_pkg::WordWidth-1:0] len,
                       input logic f, input logic l);
    @(negedge clk);
    data_word      <= w;
    byte_count     <= c;
    message_length <= len;
    first_word     <= f;
    last_word      <= l;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // drop valid for an idle gap set by n
  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_gap($urandom_range(1, 8));
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // one message of nbytes, optionally without the first mark
  task automatic send_message(input int nbytes,
                              input logic [mh64i_pkg::WordWidth-1:0] len,
                              input bit with_first, input bit empty_tail);
    int                               nfull;
    int                               tail;
    bit                               closes;
    logic [mh64i_pkg::CountWidth-1:0] c;
    nfull = nbytes / 4;
    tail  = nbytes % 4;
    for (int i = 0; i < nfull; i++) begin
      closes = (i == nfull - 1) && (tail == 0) && !empty_tail;
      if (closes) begin
        c = ($urandom_range(0, 9) == 0) ?
            mh64i_pkg::CountWidth'($urandom_range(5, 7)) : mh64i_pkg::FullCount;
      end else begin
        c = ($urandom_range(0, 9) == 0) ?
            mh64i_pkg::CountWidth'($urandom_range(0, 7)) : mh64i_pkg::FullCount;
      end
      offer($urandom, c, len, with_first && (i == 0), closes);
      pace();
    end
    if (tail != 0 || nfull == 0 || empty_tail) begin
      offer($urandom, mh64i_pkg::CountWidth'(tail), len, with_first && (nfull == 0), 1'b1);
      pace();
    end
  endtask

  // receiver stall patterns, with one long hold on request
  initial begin
    int mode;
    int seg_len;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        for (int i = 0; i < HoldCycles; i++) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(1, 60);
        for (int i = 0; i < seg_len; i++) begin
          @(negedge clk);
          case (mode)
            0: begin
              out_stall <= 1'b0;
            end
            1: begin
              out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
              out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
              out_stall <= i[0];
            end
          endcase
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int  pick;
    int  nbytes;
    bit  paused;
    logic [mh64i_pkg::WordWidth-1:0] len;
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_word      = '0;
    byte_count     = '0;
    message_length = '0;
    first_word     = 1'b0;
    last_word      = 1'b0;
    items_sent     = 0;
    burst_left     = 0;
    hold_request   = 1'b0;
    paused         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty messages, tail data beyond the count ignored
    offer(32'h0, 3'd0, 32'h0, 1'b1, 1'b1);
    pace();
    offer(32'hffffffff, 3'd0, 32'hffffffff, 1'b1, 1'b1);
    pace();
    // single full words at the extremes
    offer(32'h0, mh64i_pkg::FullCount, 32'd4, 1'b1, 1'b1);
    pace();
    offer(32'hffffffff, mh64i_pkg::FullCount, 32'd4, 1'b1, 1'b1);
    pace();
    // partial tails with high bytes set, taken as unsigned
    offer(32'hffffffff, 3'd1, 32'd1, 1'b1, 1'b1);
    pace();
    offer(32'hffffffff, 3'd2, 32'd2, 1'b1, 1'b1);
    pace();
    offer(32'hffffffff, 3'd3, 32'd3, 1'b1, 1'b1);
    pace();
    // counts above four on the last word
    offer(32'h80000001, 3'd5, 32'd4, 1'b1, 1'b1);
    pace();
    offer(32'h12345678, 3'd6, 32'd4, 1'b1, 1'b1);
    pace();
    offer(32'hdeadbeef, 3'd7, 32'd4, 1'b1, 1'b1);
    pace();
    // full last word at an odd position
    offer(32'h01020304, mh64i_pkg::FullCount, 32'd8, 1'b1, 1'b0);
    pace();
    offer(32'hfffefdfc, mh64i_pkg::FullCount, 32'd8, 1'b1 ^ 1'b1, 1'b1);
    pace();
    // partial count mid-message, full last word at an even position
    offer(32'h55555555, mh64i_pkg::FullCount, 32'd12, 1'b1, 1'b0);
    pace();
    offer(32'haaaaaaaa, 3'd2, 32'd12, 1'b0, 1'b0);
    pace();
    offer(32'h0f0f0f0f, mh64i_pkg::FullCount, 32'd12, 1'b0, 1'b1);
    pace();
    // missing first mark continues from stale lanes
    offer(32'h7fffffff, mh64i_pkg::FullCount, 32'h0, 1'b0, 1'b1);
    pace();
    // restart with first mark mid-message, length mismatch
    offer(32'hcafef00d, mh64i_pkg::FullCount, 32'hffffffff, 1'b1, 1'b0);
    pace();
    offer(32'h00c0ffee, 3'd3, 32'h0, 1'b1, 1'b0);
    pace();
    offer(32'h87654321, 3'd1, 32'd99, 1'b0, 1'b1);
    pace();
    offer(32'h0, 3'd0, 32'd7, 1'b0, 1'b1);
    pace();

    // random messages and stray words
    while (items_sent < TargetItems) begin
      if (!hold_request && items_sent > 300) begin
        hold_request = 1'b1;
      end
      if (!paused && items_sent > 700) begin
        idle_gap(1);
        wait (hashes_pending == 0);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        offer($urandom, mh64i_pkg::CountWidth'($urandom_range(0, 7)), $urandom,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pace();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          nbytes = $urandom_range(0, 24);
        end else if (pick < 97) begin
          nbytes = $urandom_range(0, 64);
        end else begin
          nbytes = $urandom_range(65, 400);
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
        send_message(nbytes, len, $urandom_range(0, 12) != 0,
                     (nbytes % 4 == 0) && nbytes > 0 && $urandom_range(0, 9) == 0);
      end
    end

    // drain and verdict
    idle_gap(1);
    wait (hashes_pending == 0);
    repeat (20) @(posedge clk);
    if (hashes_pending != 0) begin
      $display("%0t: %0d expected hash values never arrived", $time, hashes_pending);
    end
    if (mismatch_count == 0 && hashes_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
